@@ src/pie_pkg.sv @@
// Shared types, widths and codes of the power iteration eigenvector unit.
package pie_pkg;

    // Built matrix dimension
    localparam int MAX_DIM_DEF = 16;

    // Field and port widths
    localparam int ELEM_W  = 32;
    localparam int IDX_W   = 4;
    localparam int SZ_W    = 5;
    localparam int TOL_W   = 17;
    localparam int RND_W   = 8;
    localparam int EIG_W   = 31;
    localparam int STAT_W  = 2;
    localparam int CFG_A_W = 2;

    // Internal arithmetic widths
    localparam int FRAC      = 16;
    localparam int Y_W       = 46;
    localparam int V_W       = 32;
    localparam int VEC_W     = Y_W + V_W;
    localparam int DIV_NUM_W = 61;
    localparam int DIV_DEN_W = 32;
    localparam int SQ_IN_W   = 64;
    localparam int SQ_OUT_W  = 32;
    localparam int STEP_W    = 56;
    localparam int TOL2_W    = 46;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_SIZE   = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_TOL    = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_ROUNDS = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_CONV  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_LIMIT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BREAK = 2'd2;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_SDIV,
        S_SDIVW,
        S_SSQW,
        S_FILL,
        S_ROW,
        S_RWAIT,
        S_REND,
        S_SQZ,
        S_SSADD,
        S_NSQ,
        S_NSQW,
        S_NRD,
        S_NDV,
        S_NDVW,
        S_NSQE,
        S_NACC,
        S_RDONE,
        S_BRK,
        S_FIN,
        S_FINW,
        S_ORD,
        S_OMUL,
        S_OUT
    } t_state;

endpackage

@@ src/power_iteration_eigenvector_unit.sv @@
// Dominant eigenpair of a symmetric matrix by power iteration over a matrix and a vector memory.
// Matrix elements load one item per cycle into the matrix memory while no run is in progress.
// The item with start_run set starts a run; input stalls until the run's n results are delivered.
// Setup computes the reciprocal of n and its square root. Each round runs the matrix-vector
// product, the norm and the normalization, which is dominated by the one-bit-per-cycle divider.
// A run ends with a square root, skipped on breakdown, and then the n results, each held while
// the output is stalled.
module power_iteration_eigenvector_unit #(
    parameter int MAX_DIM = pie_pkg::MAX_DIM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [pie_pkg::CFG_A_W-1:0]        i_cfg_index,
    input  logic [pie_pkg::TOL_W-1:0]          i_cfg_wdata,
    // input items
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [pie_pkg::IDX_W-1:0]          i_row_index,
    input  logic [pie_pkg::IDX_W-1:0]          i_col_index,
    input  logic signed [pie_pkg::ELEM_W-1:0]  i_element_value,
    input  logic                               i_start_run,
    // result items
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [pie_pkg::IDX_W-1:0]          o_entry_index,
    output logic signed [pie_pkg::ELEM_W-1:0]  o_scaled_entry,
    output logic [pie_pkg::EIG_W-1:0]          o_eigenvalue,
    output logic [pie_pkg::STAT_W-1:0]         o_status,
    output logic                               o_last_entry
);
    import pie_pkg::*;

    localparam int IW    = $clog2(MAX_DIM);
    localparam int MA_W  = $clog2(MAX_DIM * MAX_DIM);
    localparam int ACC_W = 2 * ELEM_W - FRAC + IW + 1;
    localparam logic signed [ACC_W-1:0] Y_LIM  = ACC_W'(64'd1 << (Y_W - 1));
    localparam logic signed [ACC_W-1:0] Y_NLIM = -Y_LIM;
    localparam logic [SQ_IN_W-1:0]      SS_LIM = SQ_IN_W'(64'd1 << 62);

    // Configuration registers
    logic [SZ_W-1:0]  r_size;
    logic [TOL_W-1:0] r_tol;
    logic [RND_W-1:0] r_max_rounds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size       <= SZ_W'(16);
            r_tol        <= TOL_W'(1);
            r_max_rounds <= RND_W'(100);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SIZE:   r_size       <= i_cfg_wdata[SZ_W-1:0];
                CFG_TOL:    r_tol        <= i_cfg_wdata;
                CFG_ROUNDS: r_max_rounds <= i_cfg_wdata[RND_W-1:0];
                default:    ;
            endcase
        end
    end

    t_state r_state, n_state;

    logic in_acc, out_acc;
    logic row_ok, col_ok;
    logic [SZ_W-1:0] n_dim;
    logic [IW-1:0]   r_nm1, r_i, r_j;
    logic i_last, j_last;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;
    assign row_ok  = {1'b0, i_row_index} < (IDX_W + 1)'(MAX_DIM);
    assign col_ok  = {1'b0, i_col_index} < (IDX_W + 1)'(MAX_DIM);
    assign i_last  = (r_i == r_nm1);
    assign j_last  = (r_j == r_nm1);

    // Clamp the dimension into the built range
    always_comb begin
        if (r_size == '0) begin
            n_dim = SZ_W'(1);
        end else if (r_size > SZ_W'(MAX_DIM)) begin
            n_dim = SZ_W'(MAX_DIM);
        end else begin
            n_dim = r_size;
        end
    end

    // Shared units
    logic                  div_start, div_busy, div_done;
    logic [DIV_NUM_W-1:0]  div_num, div_quot;
    logic [DIV_DEN_W-1:0]  div_den;
    logic                  sq_start, sq_busy, sq_done;
    logic [SQ_IN_W-1:0]    sq_rad;
    logic [SQ_OUT_W-1:0]   sq_root;

    pie_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    pie_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (sq_rad),
        .o_busy     (sq_busy),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    // Matrix memory
    logic signed [ELEM_W-1:0] r_mat [MAX_DIM * MAX_DIM];
    logic signed [ELEM_W-1:0] r_mrd;
    logic                     mat_we, mat_re;
    logic [MA_W-1:0]          mat_wa, mat_ra;

    assign mat_we = in_acc && row_ok && col_ok;
    assign mat_wa = MA_W'(i_row_index) * MA_W'(MAX_DIM) + MA_W'(i_col_index);
    assign mat_ra = MA_W'(r_i) * MA_W'(MAX_DIM) + MA_W'(r_j);

    always_ff @(posedge i_clk) begin
        if (mat_we) begin
            r_mat[mat_wa] <= i_element_value;
        end
        if (mat_re) begin
            r_mrd <= r_mat[mat_ra];
        end
    end

    // Vector memory: y of the round above the vector entry
    logic [VEC_W-1:0] r_vec [MAX_DIM];
    logic [VEC_W-1:0] r_vrd;
    logic [VEC_W-1:0] vec_wd;
    logic             vec_we, vec_re;
    logic [IW-1:0]    vec_ra;

    always_ff @(posedge i_clk) begin
        if (vec_we) begin
            r_vec[r_i] <= vec_wd;
        end
        if (vec_re) begin
            r_vrd <= r_vec[vec_ra];
        end
    end

    logic signed [Y_W-1:0] vrd_y;
    logic signed [V_W-1:0] vrd_v;
    assign vrd_y = signed'(r_vrd[VEC_W-1:V_W]);
    assign vrd_v = signed'(r_vrd[V_W-1:0]);

    // Datapath registers
    logic [V_W-1:0]              r_startv;
    logic [TOL2_W-1:0]           r_tol2;
    logic [RND_W:0]              r_k;
    logic signed [2*ELEM_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic [V_W-1:0]              r_vi;
    logic                        r_p1, r_p1_last, r_p2, r_p2_last, r_rdone;
    logic [IW-1:0]               r_p1_j;
    logic [SQ_OUT_W-1:0]         r_zmag;
    logic [SQ_IN_W-1:0]          r_zz, r_ss;
    logic [SQ_OUT_W-1:0]         r_norm, r_normv, r_s;
    logic [24:0]                 r_emag;
    logic [49:0]                 r_ee;
    logic [STEP_W-1:0]           r_step;
    logic [STAT_W-1:0]           r_status;
    logic [2*V_W-1:0]            r_om;
    logic                        r_oneg;

    // Row product helpers
    logic signed [ACC_W-1:0] prod_sh;
    logic                    acc_big;
    logic signed [V_W-1:0]   z;
    logic [SQ_OUT_W-1:0]     zmag;
    logic [SQ_IN_W-1:0]      ss_sum;
    logic                    issue;

    assign prod_sh = signed'({{(ACC_W - (2 * ELEM_W - FRAC)){r_prod[2*ELEM_W-1]}},
                              r_prod[2*ELEM_W-1:FRAC]});
    assign acc_big = (r_acc >= Y_LIM) || (r_acc <= Y_NLIM);
    assign z       = signed'(r_acc[Y_W-1:14]);
    assign zmag    = z[V_W-1] ? V_W'(-z) : V_W'(z);
    assign ss_sum  = r_ss + r_zz;
    assign issue   = (r_state == S_ROW);

    // Normalization helpers
    logic [Y_W-1:0]        ymag;
    logic [V_W-2:0]        qsat;
    logic signed [V_W-1:0] vnew;
    logic signed [V_W:0]   vdiff;
    logic signed [24:0]    e;
    logic [24:0]           emag;
    logic [V_W-1:0]        vmag;

    assign ymag  = vrd_y[Y_W-1] ? Y_W'(-vrd_y) : Y_W'(vrd_y);
    assign qsat  = (div_quot > DIV_NUM_W'(32'h7FFF_FFFF)) ? {(V_W - 1){1'b1}}
                                                         : div_quot[V_W-2:0];
    assign vnew  = vrd_y[Y_W-1] ? -signed'({1'b0, qsat}) : signed'({1'b0, qsat});
    assign vdiff = {vrd_v[V_W-1], vrd_v} - {vnew[V_W-1], vnew};
    assign e     = vdiff[V_W:8];
    assign emag  = e[24] ? 25'(-e) : 25'(e);
    assign vmag  = vrd_v[V_W-1] ? V_W'(-vrd_v) : V_W'(vrd_v);

    // Hold the row product pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1    <= 1'b0;
            r_p2    <= 1'b0;
            r_rdone <= 1'b0;
        end else begin
            r_p1    <= issue;
            r_p2    <= r_p1;
            r_rdone <= r_p2 && r_p2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_j    <= r_j;
        r_p1_last <= j_last;
        r_p2_last <= r_p1_last;
        if (r_p1) begin
            r_prod <= r_mrd * vrd_v;
            if (r_p1_j == r_i) begin
                r_vi <= r_vrd[V_W-1:0];
            end
        end
        if (issue && r_j == '0) begin
            r_acc <= '0;
        end else if (r_p2) begin
            r_acc <= r_acc + prod_sh;
        end
    end

    // Advance the sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_start_run) begin
                    r_nm1  <= IW'(n_dim - 1'b1);
                    r_tol2 <= {r_tol, 6'd0} * {r_tol, 6'd0};
                end
            end
            S_SSQW: begin
                r_startv <= sq_root;
                r_i      <= '0;
            end
            S_FILL: begin
                r_i <= i_last ? '0 : r_i + 1'b1;
                if (i_last) begin
                    r_j  <= '0;
                    r_k  <= '0;
                    r_ss <= '0;
                end
            end
            S_ROW: begin
                r_j <= j_last ? '0 : r_j + 1'b1;
            end
            S_REND: begin
                r_zmag <= zmag;
            end
            S_SQZ: begin
                r_zz <= SQ_IN_W'(r_zmag) * SQ_IN_W'(r_zmag);
            end
            S_SSADD: begin
                r_ss <= ss_sum;
                if (!i_last) begin
                    r_i <= r_i + 1'b1;
                end
                r_j <= '0;
            end
            S_NSQW: begin
                r_norm <= sq_root;
                r_i    <= '0;
                r_step <= '0;
            end
            S_NDVW: begin
                r_emag <= emag;
            end
            S_NSQE: begin
                r_ee <= 50'(r_emag) * 50'(r_emag);
            end
            S_NACC: begin
                r_step <= r_step + STEP_W'(r_ee);
                if (!i_last) begin
                    r_i <= r_i + 1'b1;
                end
            end
            S_RDONE: begin
                r_normv  <= r_norm;
                r_k      <= r_k + 1'b1;
                r_status <= ((r_k + 1'b1) > {1'b0, r_max_rounds}) ? STAT_LIMIT : STAT_CONV;
                r_i      <= '0;
                r_j      <= '0;
                r_ss     <= '0;
            end
            S_BRK: begin
                r_normv  <= '0;
                r_s      <= '0;
                r_status <= STAT_BREAK;
                r_i      <= '0;
            end
            S_FINW: begin
                r_s <= sq_root;
                r_i <= '0;
            end
            S_OMUL: begin
                r_om   <= vmag * r_s;
                r_oneg <= vrd_v[V_W-1];
            end
            S_OUT: begin
                if (out_acc && !i_last) begin
                    r_i <= r_i + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc && i_start_run) n_state = S_SDIV;
            S_SDIV:  n_state = S_SDIVW;
            S_SDIVW: if (div_done) n_state = S_SSQW;
            S_SSQW:  if (sq_done) n_state = S_FILL;
            S_FILL:  if (i_last) n_state = S_ROW;
            S_ROW:   if (j_last) n_state = S_RWAIT;
            S_RWAIT: if (r_rdone) n_state = S_REND;
            S_REND:  n_state = acc_big ? S_BRK : S_SQZ;
            S_SQZ:   n_state = S_SSADD;
            S_SSADD: begin
                if (ss_sum >= SS_LIM) begin
                    n_state = S_BRK;
                end else if (i_last) begin
                    n_state = S_NSQ;
                end else begin
                    n_state = S_ROW;
                end
            end
            S_NSQ:   n_state = S_NSQW;
            S_NSQW:  if (sq_done) n_state = (sq_root == '0) ? S_BRK : S_NRD;
            S_NRD:   n_state = S_NDV;
            S_NDV:   n_state = S_NDVW;
            S_NDVW:  if (div_done) n_state = S_NSQE;
            S_NSQE:  n_state = S_NACC;
            S_NACC:  n_state = i_last ? S_RDONE : S_NRD;
            S_RDONE: begin
                if ((r_k + 1'b1) > {1'b0, r_max_rounds}) begin
                    n_state = S_FIN;
                end else if (r_step <= STEP_W'(r_tol2)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_ROW;
                end
            end
            S_BRK:   n_state = S_ORD;
            S_FIN:   n_state = S_FINW;
            S_FINW:  if (sq_done) n_state = S_ORD;
            S_ORD:   n_state = S_OMUL;
            S_OMUL:  n_state = S_OUT;
            S_OUT:   if (out_acc) n_state = i_last ? S_IDLE : S_ORD;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Drive memory ports and unit starts
    always_comb begin
        mat_re    = 1'b0;
        vec_re    = 1'b0;
        vec_ra    = r_i;
        vec_we    = 1'b0;
        vec_wd    = {{Y_W{1'b0}}, r_startv};
        div_start = 1'b0;
        div_num   = {ymag[Y_W-2:0], {FRAC{1'b0}}};
        div_den   = DIV_DEN_W'(r_norm);
        sq_start  = 1'b0;
        sq_rad    = r_ss;
        case (r_state)
            S_SDIV: begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(1) << 60;
                div_den   = DIV_DEN_W'(r_nm1) + 1'b1;
            end
            S_SDIVW: begin
                sq_start = div_done;
                sq_rad   = SQ_IN_W'(div_quot);
            end
            S_FILL: begin
                vec_we = 1'b1;
            end
            S_ROW: begin
                mat_re = 1'b1;
                vec_re = 1'b1;
                vec_ra = r_j;
            end
            S_REND: begin
                vec_we = !acc_big;
                vec_wd = {r_acc[Y_W-1:0], r_vi};
            end
            S_NSQ: begin
                sq_start = 1'b1;
            end
            S_NRD, S_ORD: begin
                vec_re = 1'b1;
            end
            S_NDV: begin
                div_start = 1'b1;
            end
            S_NDVW: begin
                vec_we = div_done;
                vec_wd = {vrd_y, vnew};
            end
            S_FIN: begin
                sq_start = 1'b1;
                sq_rad   = SQ_IN_W'(r_normv) << FRAC;
            end
            default: ;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // Result fields
    logic [V_W-1:0] om_q;
    assign om_q           = r_om[V_W+29:30];
    assign o_entry_index  = IDX_W'(r_i);
    assign o_scaled_entry = r_oneg ? -signed'(om_q) : signed'(om_q);
    assign o_eigenvalue   = r_normv[EIG_W-1:0];
    assign o_status       = r_status;
    assign o_last_entry   = i_last;

    // Checks
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_sq_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_start |-> !sq_busy)
        else $error("square root started while busy");

    a_break_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STAT_BREAK) |-> (o_eigenvalue == '0 && o_scaled_entry == '0))
        else $error("breakdown result carries nonzero values");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last_entry) |=> (r_state == S_IDLE))
        else $error("run did not end after last item");

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW) |-> (r_k <= {1'b0, r_max_rounds}))
        else $error("round started past the limit");

endmodule

@@ src/pie_div.sv @@
// Restoring divider, one quotient bit per cycle.
module pie_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pie_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [pie_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                           o_busy,
    output logic                           o_done,
    output logic [pie_pkg::DIV_NUM_W-1:0]  o_quot
);
    import pie_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_NUM_W-1:0] r_quot;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 ge;

    // Shift in the next numerator bit and try the subtract
    assign rem_sh  = {r_rem, r_num[DIV_NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    // Track busy and flag the last bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Advance remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= r_num << 1;
            r_rem  <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            r_quot <= {r_quot[DIV_NUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ src/pie_isqrt.sv @@
// Integer square root, one result bit per cycle.
module pie_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pie_pkg::SQ_IN_W-1:0]   i_radicand,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [pie_pkg::SQ_OUT_W-1:0]  o_root
);
    import pie_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [SQ_IN_W-1:0] r_x;
    logic [SQ_IN_W-1:0] r_r;
    logic [SQ_IN_W-1:0] r_b;
    logic [SQ_IN_W-1:0] sum_rb;
    logic               ge;

    assign sum_rb = r_r + r_b;
    assign ge     = r_x >= sum_rb;

    // Track busy; the last step runs with the lowest bit pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_b[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Advance the digit-by-digit root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_radicand;
            r_r <= '0;
            r_b <= SQ_IN_W'(1) << (SQ_IN_W - 2);
        end else if (r_busy) begin
            if (ge) begin
                r_x <= r_x - sum_rb;
                r_r <= (r_r >> 1) + r_b;
            end else begin
                r_r <= r_r >> 1;
            end
            r_b <= r_b >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_r[SQ_OUT_W-1:0];

endmodule
